[rtl/assert_macros.svh]
// Assertion helpers: real checks in simulation, empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, held off while reset is low.
`define CTKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also during reset.
`define CTKD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTKD_ASSERT(lbl, prop, msg)
`define CTKD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/ctkd_pkg.sv]
package ctkd_pkg;

  localparam int MAX_LINKS_DEF    = 8;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ANG_W  = 37;  // Q30 angle before range reduction
  localparam int TRIG_W = 33;  // Q2.30 sine, cosine, residual angle
  localparam int MUL_W  = 34;
  localparam int PROD_W = 68;
  localparam int DIV_W  = 59;  // tangent numerator magnitude
  localparam int DCW    = $clog2(DIV_W);

  localparam logic [1:0] CFG_FWD   = 2'd0;
  localparam logic [1:0] CFG_INV_L = 2'd1;
  localparam logic [1:0] CFG_INV_H = 2'd2;
  localparam logic [1:0] CFG_LINKS = 2'd3;

  localparam logic signed [ANG_W-1:0]  Q30_PI      = 37'sd3373259426;
  localparam logic signed [ANG_W-1:0]  Q30_HALF_PI = 37'sd1686629713;
  localparam logic signed [ANG_W-1:0]  Q30_TWO_PI  = 37'sd6746518852;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sh026DD3B6A;

  localparam logic signed [PROD_W-1:0] S24_MAX = 68'sd8388607;
  localparam logic signed [PROD_W-1:0] S24_MIN = -68'sd8388608;
  localparam logic signed [PROD_W-1:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN = -68'sd2147483648;

  typedef enum logic [1:0] {
    COR_IDLE, COR_REDUCE, COR_ROTATE, COR_DONE
  } cor_state_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SC1, ST_SC2,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7,
    ST_DIV, ST_L0, ST_L1, ST_L2, ST_OUT
  } ctkd_state_t;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [TRIG_W-1:0] r;
    case (idx)
      5'd0:  r = 33'sh03243F6A8;
      5'd1:  r = 33'sh01DAC6705;
      5'd2:  r = 33'sh00FADBAFC;
      5'd3:  r = 33'sh007F56EA6;
      5'd4:  r = 33'sh003FEAB76;
      5'd5:  r = 33'sh001FFD55B;
      5'd6:  r = 33'sh000FFFAAA;
      5'd7:  r = 33'sh0007FFF55;
      5'd8:  r = 33'sh0003FFFEA;
      5'd9:  r = 33'sh0001FFFFD;
      5'd10: r = 33'sh0000FFFFF;
      5'd11: r = 33'sh00007FFFF;
      5'd12: r = 33'sh00003FFFF;
      5'd13: r = 33'sh00001FFFF;
      5'd14: r = 33'sh00000FFFF;
      5'd15: r = 33'sh000007FFF;
      5'd16: r = 33'sh000003FFF;
      5'd17: r = 33'sh000001FFF;
      5'd18: r = 33'sh000000FFF;
      5'd19: r = 33'sh0000007FF;
      5'd20: r = 33'sh0000003FF;
      5'd21: r = 33'sh0000001FF;
      5'd22: r = 33'sh0000000FF;
      5'd23: r = 33'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Add half an LSB, then floor shift.
  function automatic logic signed [PROD_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p,
                                                     input int n);
    logic signed [PROD_W-1:0] half;
    half = '0;
    half[n-1] = 1'b1;
    return (p + half) >>> n;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX) r = 24'sh7FFFFF;
    else if (v < S24_MIN) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic ovf24(input logic signed [PROD_W-1:0] v);
    return (v > S24_MAX) || (v < S24_MIN);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFFFFFF;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [PROD_W-1:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

endpackage

[rtl/ctkd_cordic.sv]
module ctkd_cordic import ctkd_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start_i,
  input  logic signed [ANG_W-1:0]  angle_i,
  output logic                     done_o,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  cor_state_t               state_r, state_nxt;
  logic signed [ANG_W-1:0]  a_r;
  logic signed [TRIG_W-1:0] x_r, y_r, z_r;
  logic                     neg_r;
  logic [IW-1:0]            i_r;
  logic                     in_range;

  assign in_range = (a_r <= Q30_PI) && (a_r >= -Q30_PI);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      COR_IDLE:   if (start_i) state_nxt = COR_REDUCE;
      COR_REDUCE: if (in_range) state_nxt = COR_ROTATE;
      COR_ROTATE: if (i_r == IW'(CORDIC_STEPS - 1)) state_nxt = COR_DONE;
      // a new start may follow straight on from a finished evaluation
      COR_DONE:   state_nxt = start_i ? COR_REDUCE : COR_IDLE;
      default:    state_nxt = COR_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_r == COR_DONE);
    sin_o  = neg_r ? -y_r : y_r;
    cos_o  = neg_r ? -x_r : x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= COR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      COR_IDLE, COR_DONE: begin
        a_r <= angle_i;
      end
      COR_REDUCE: begin
        // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
        if (a_r > Q30_PI) begin
          a_r <= a_r - Q30_TWO_PI;
        end else if (a_r < -Q30_PI) begin
          a_r <= a_r + Q30_TWO_PI;
        end else begin
          x_r <= CORDIC_GAIN;
          y_r <= '0;
          i_r <= '0;
          if (a_r > Q30_HALF_PI) begin
            z_r   <= TRIG_W'(a_r - Q30_PI);
            neg_r <= 1'b1;
          end else if (a_r < -Q30_HALF_PI) begin
            z_r   <= TRIG_W'(a_r + Q30_PI);
            neg_r <= 1'b1;
          end else begin
            z_r   <= TRIG_W'(a_r);
            neg_r <= 1'b0;
          end
        end
      end
      COR_ROTATE: begin
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> i_r);
          y_r <= y_r + (x_r >>> i_r);
          z_r <= z_r - atan_q30(5'(i_r));
        end else begin
          x_r <= x_r + (y_r >>> i_r);
          y_r <= y_r - (x_r >>> i_r);
          z_r <= z_r + atan_q30(5'(i_r));
        end
        i_r <= i_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/car_trailer_kinematics_derivative_unit.sv]
// Channel  Direction  Handshake          Payload
// in_      slave      tvalid / tready    tdata: item fields, tuser: kind
// out_     master     tvalid / tready    tdata: rates, link number; tlast; tuser
// cfg_     write      cfg_we             cfg_addr, cfg_wdata
//
// One transaction in flight at a time; in_tready is high only while idle.
// A single CORDIC and a single multiplier serve every step; a rear-wheel head then runs
// the restoring divider for its 59 quotient bits, one a cycle, and skips it on a zero
// steer cosine. Each CORDIC angle is wrapped by 2*pi one step at a time. The output register
// holds a result while out_tready is low; a new input transaction is still taken
// meanwhile. Reset is synchronous, active low.
module car_trailer_kinematics_derivative_unit import ctkd_pkg::*; #(
  parameter int MAX_LINKS    = MAX_LINKS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // heading[15:0], speed[39:16], steer_angle[55:40], accel_cmd[79:56],
  // steer_rate_cmd[103:80], link_angle[119:104]
  input  logic [119:0]  in_tdata,
  // kind[0]
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // deriv_x[23:0], deriv_y[47:24], deriv_heading[71:48], deriv_speed[95:72],
  // deriv_steer[119:96], deriv_link[143:120], link_number[147:144], zero pad
  output logic [151:0]  out_tdata,
  output logic          out_tlast,
  // saturated[0]
  output logic          out_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [23:0]   cfg_wdata
);

  // configuration
  logic        fwd_r;
  logic [23:0] inv_len_r, inv_hitch_r;
  logic [3:0]  link_cnt_r, eff_links;

  // sequencer and captured item
  ctkd_state_t state_r, state_nxt;
  logic               kind_r;
  logic signed [15:0] head_r, steer_r, link_ang_r;
  logic signed [23:0] speed_r, accel_r, srate_r;

  // persistent vehicle state
  logic signed [31:0] coeff_r;
  logic signed [15:0] prev_r;
  logic [3:0]         pos_r;

  // work registers
  logic signed [TRIG_W-1:0] sh_r, ch_r, ss_r, cs_r, c_r, sy_r;
  logic signed [MUL_W-1:0]  t1_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [23:0]       dx_r, dy_r, dh_r, dl_r;
  logic                     flag_r;

  // divider
  logic [DIV_W-1:0]  quo_r;
  logic [TRIG_W-1:0] rem_r, den_r;
  logic [DCW-1:0]    div_cnt_r;
  logic              qneg_r, t2neg_r;
  logic [TRIG_W:0]   div_shift;
  logic              div_bit;
  logic signed [PROD_W-1:0] div_q;

  // output register
  logic               out_valid_r;
  logic [151:0]       out_data_r;
  logic               out_last_r, out_sat_r;

  // control
  logic                    accept, out_load;
  logic                    cor_start, cor_done;
  logic signed [16:0]      ang17;
  logic signed [ANG_W-1:0] cor_angle;
  logic signed [TRIG_W-1:0] cor_sin, cor_cos;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [MUL_W-1:0] v_op, invl_op, invh_op, coeff_op;
  logic [3:0]              pos_inc;

  assign accept   = in_tvalid && in_tready;
  assign eff_links = (int'(link_cnt_r) > MAX_LINKS) ? 4'(MAX_LINKS) : link_cnt_r;
  assign v_op     = MUL_W'(speed_r);
  assign invl_op  = MUL_W'({1'b0, inv_len_r});
  assign invh_op  = MUL_W'({1'b0, inv_hitch_r});
  assign coeff_op = MUL_W'(coeff_r);
  assign pos_inc  = (pos_r < 4'd15) ? pos_r + 4'd1 : pos_r;

  // CORDIC angle: the first evaluation takes its angle off the bus (a link's as the previous angle less its own)
  always_comb begin
    if (state_r == ST_IDLE) begin
      if (in_tuser) ang17 = 17'(prev_r) - 17'($signed(in_tdata[119:104]));
      else          ang17 = 17'($signed(in_tdata[15:0]));
    end else begin
      ang17 = 17'(steer_r);
    end
    cor_angle = {{(ANG_W-35){ang17[16]}}, ang17, 18'b0};
  end

  ctkd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SC1;
      ST_SC1:  if (cor_done) state_nxt = kind_r ? ST_L0 : ST_SC2;
      ST_SC2:  if (cor_done) state_nxt = ST_H0;
      ST_H0:   state_nxt = ST_H1;
      ST_H1:   state_nxt = ST_H2;
      ST_H2:   state_nxt = ST_H3;
      ST_H3:   state_nxt = ST_H4;
      ST_H4:   state_nxt = ST_H5;
      ST_H5: begin
        if (fwd_r)         state_nxt = ST_H6;
        else if (cs_r == 0) state_nxt = ST_OUT;
        else                state_nxt = ST_DIV;
      end
      ST_H6:   state_nxt = ST_H7;
      ST_H7:   state_nxt = ST_OUT;
      ST_DIV:  if (div_cnt_r == DCW'(DIV_W - 1)) state_nxt = ST_OUT;
      ST_L0:   state_nxt = ST_L1;
      ST_L1:   state_nxt = ST_L2;
      ST_L2:   state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs: multiplier operands launched in each state
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    cor_start = accept || (state_r == ST_SC1 && cor_done && !kind_r);
    out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_H0: begin mul_a = v_op; mul_b = MUL_W'(ss_r); end
      ST_H1: begin
        mul_a = fwd_r ? MUL_W'(ch_r) : v_op;
        mul_b = fwd_r ? MUL_W'(cs_r) : MUL_W'(ch_r);
      end
      ST_H2: begin
        mul_a = fwd_r ? MUL_W'(sh_r) : v_op;
        mul_b = fwd_r ? MUL_W'(cs_r) : MUL_W'(sh_r);
      end
      ST_H3: begin
        mul_a = fwd_r ? v_op : t1_r;
        mul_b = fwd_r ? MUL_W'(c_r) : invl_op;
      end
      ST_H4: begin
        mul_a = v_op;
        mul_b = fwd_r ? MUL_W'(sy_r) : invh_op;
      end
      ST_H5: begin mul_a = t1_r; mul_b = invl_op; end
      ST_H6: begin mul_a = v_op; mul_b = invh_op; end
      ST_L0: begin mul_a = coeff_op; mul_b = MUL_W'(sh_r); end
      ST_L1: begin mul_a = coeff_op; mul_b = MUL_W'(ch_r); end
      default: begin
      end
    endcase
  end

  // restoring divider step; the final quotient takes its last bit from the compare
  always_comb begin
    div_shift = {rem_r, quo_r[DIV_W-1]};
    div_bit   = (div_shift >= {1'b0, den_r});
    div_q     = qneg_r ? -PROD_W'({1'b0, quo_r[DIV_W-2:0], div_bit})
                       : PROD_W'({1'b0, quo_r[DIV_W-2:0], div_bit});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fwd_r       <= 1'b0;
      inv_len_r   <= 24'h100000;
      inv_hitch_r <= 24'h100000;
      link_cnt_r  <= 4'd0;
      coeff_r     <= '0;
      prev_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FWD:   fwd_r       <= cfg_wdata[0];
          CFG_INV_L: inv_len_r   <= cfg_wdata;
          CFG_INV_H: inv_hitch_r <= cfg_wdata;
          CFG_LINKS: link_cnt_r  <= cfg_wdata[3:0];
          default: begin
          end
        endcase
      end
      // commit the running coefficient and link chain
      case (state_r)
        ST_H5: if (!fwd_r) coeff_r <= sat32(rnd_q(p_r, 16));
        ST_H7: coeff_r <= sat32(rnd_q(p_r, 16));
        ST_L2: begin
          coeff_r <= sat32(rnd_q(p_r, 30));
          prev_r  <= link_ang_r;
          pos_r   <= pos_inc;
        end
        default: begin
        end
      endcase
      if (state_r == ST_H0) begin
        prev_r <= head_r;
        pos_r  <= '0;
      end
      if (out_load)                  out_valid_r <= 1'b1;
      else if (out_tready)           out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (accept) begin
      kind_r     <= in_tuser;
      head_r     <= $signed(in_tdata[15:0]);
      speed_r    <= $signed(in_tdata[39:16]);
      steer_r    <= $signed(in_tdata[55:40]);
      accel_r    <= $signed(in_tdata[79:56]);
      srate_r    <= $signed(in_tdata[103:80]);
      link_ang_r <= $signed(in_tdata[119:104]);
      dx_r   <= '0;
      dy_r   <= '0;
      dh_r   <= '0;
      dl_r   <= '0;
      flag_r <= 1'b0;
    end
    case (state_r)
      ST_SC1: if (cor_done) begin sh_r <= cor_sin; ch_r <= cor_cos; end
      ST_SC2: if (cor_done) begin ss_r <= cor_sin; cs_r <= cor_cos; end
      ST_H1: t1_r <= MUL_W'(rnd_q(p_r, 30));
      ST_H2: begin
        if (fwd_r) begin
          c_r <= TRIG_W'(rnd_q(p_r, 30));
        end else begin
          dx_r <= sat24(rnd_q(p_r, 30));
          if (ovf24(rnd_q(p_r, 30))) flag_r <= 1'b1;
        end
      end
      ST_H3: begin
        if (fwd_r) begin
          sy_r <= TRIG_W'(rnd_q(p_r, 30));
        end else begin
          dy_r <= sat24(rnd_q(p_r, 30));
          if (ovf24(rnd_q(p_r, 30))) flag_r <= 1'b1;
        end
      end
      ST_H4: begin
        if (fwd_r) begin
          dx_r <= sat24(rnd_q(p_r, 30));
          if (ovf24(rnd_q(p_r, 30))) flag_r <= 1'b1;
        end else begin
          // tangent numerator t1*invL*1024, kept as sign and magnitude
          t2neg_r   <= p_r[PROD_W-1];
          quo_r     <= p_r[PROD_W-1] ? DIV_W'((-p_r) <<< 10) : DIV_W'(p_r <<< 10);
          qneg_r    <= p_r[PROD_W-1] ^ cs_r[TRIG_W-1];
          den_r     <= cs_r[TRIG_W-1] ? TRIG_W'(-cs_r) : TRIG_W'(cs_r);
          rem_r     <= '0;
          div_cnt_r <= '0;
        end
      end
      ST_H5: begin
        if (fwd_r) begin
          dy_r <= sat24(rnd_q(p_r, 30));
          if (ovf24(rnd_q(p_r, 30))) flag_r <= 1'b1;
        end else begin
          // zero cosine: clip toward the numerator's sign
          if (cs_r == 0 && quo_r != '0) dh_r <= t2neg_r ? 24'sh800000 : 24'sh7FFFFF;
          if (ovf32(rnd_q(p_r, 16)) || (cs_r == 0 && quo_r != '0)) flag_r <= 1'b1;
        end
      end
      ST_H6: begin
        dh_r <= sat24(rnd_q(p_r, 20));
        if (ovf24(rnd_q(p_r, 20))) flag_r <= 1'b1;
      end
      ST_H7: if (ovf32(rnd_q(p_r, 16))) flag_r <= 1'b1;
      ST_DIV: begin
        if (div_cnt_r == DCW'(DIV_W - 1)) begin
          dh_r <= sat24(div_q);
          if (ovf24(div_q)) flag_r <= 1'b1;
        end else begin
          quo_r     <= {quo_r[DIV_W-2:0], div_bit};
          rem_r     <= div_bit ? TRIG_W'(div_shift - {1'b0, den_r}) : TRIG_W'(div_shift);
          div_cnt_r <= div_cnt_r + 1'b1;
        end
      end
      ST_L1: begin
        dl_r <= sat24(rnd_q(p_r, 34));
        if (ovf24(rnd_q(p_r, 34))) flag_r <= 1'b1;
      end
      ST_L2: if (ovf32(rnd_q(p_r, 30))) flag_r <= 1'b1;
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r <= {4'b0, (kind_r ? pos_r : 4'd0), dl_r,
                     (kind_r ? 24'd0 : srate_r), (kind_r ? 24'd0 : accel_r),
                     dh_r, dy_r, dx_r};
      out_last_r <= kind_r ? (pos_r == eff_links) : (eff_links == 4'd0);
      out_sat_r  <= flag_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_sat_r;

`include "assert_macros.svh"
  `CTKD_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "ready after accept")
  `CTKD_ASSERT(a_out_held, (state_r == ST_OUT && out_valid_r && !out_tready) |=> (state_r == ST_OUT), "result overwritten")
  `CTKD_ASSERT(a_cordic_wait, cor_done |-> (state_r == ST_SC1 || state_r == ST_SC2), "stray cordic done")
  `CTKD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset state")

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import ctkd_pkg::*;

  localparam int NUM_STEPS = CORDIC_STEPS_DEF;
  localparam int LINK_CAP  = MAX_LINKS_DEF;

  typedef struct {
    bit                 kind;
    logic signed [15:0] heading;
    logic signed [23:0] speed;
    logic signed [15:0] steer;
    logic signed [23:0] accel;
    logic signed [23:0] steer_rate;
    logic signed [15:0] link_angle;
  } veh_item_t;

  typedef struct {
    logic [23:0] dx, dy, dh, dv, ds, dl;
    logic [3:0]  num;
    logic        last;
    logic        sat;
  } rate_set_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // heading, speed, steer_angle, accel_cmd, steer_rate_cmd, link_angle (low bit up)
  logic [119:0] in_tdata = '0;
  // kind
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // deriv_x, deriv_y, deriv_heading, deriv_speed, deriv_steer, deriv_link,
  // link_number, zero pad (low bit up)
  logic [151:0] out_tdata;
  logic         out_tlast;
  // saturated
  logic         out_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [23:0]  cfg_wdata = '0;

  car_trailer_kinematics_derivative_unit uut (.*);

  always #6 clk = ~clk;

  // Shadow copy of the block's registers and running state
  bit     fwd_mode;
  longint inv_body, inv_hitch;
  int     links_cfg;
  longint coeff_q16;
  longint prev_ang;
  int     link_pos;

  veh_item_t pending_items[$];
  rate_set_t expected_rates[$];
  int        n_accepted;
  int        n_mismatch;
  bit        failed;

  longint atan_tab[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  function automatic longint round_shift(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, int bits, inout bit flag);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Q3.12 angle in, Q2.30 sine and cosine out
  task automatic angle_sincos(input longint a12, output longint sn, output longint cs);
    longint a, x, y, z, tx, ty;
    bit     flip;
    a = a12 * 262144;
    flip = 1'b0;
    x = 64'h26DD3B6A;
    y = 0;
    while (a > 64'sd3373259426) a -= 64'sd6746518852;
    while (a < -64'sd3373259426) a += 64'sd6746518852;
    if (a > 64'sd1686629713) begin
      a -= 64'sd3373259426;
      flip = 1'b1;
    end else if (a < -64'sd1686629713) begin
      a += 64'sd3373259426;
      flip = 1'b1;
    end
    z = a;
    for (int i = 0; i < NUM_STEPS && i < 24; i++) begin
      tx = y >>> i;
      ty = x >>> i;
      if (z >= 0) begin
        x -= tx; y += ty; z -= atan_tab[i];
      end else begin
        x += tx; y -= ty; z += atan_tab[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // Work out the rates for one accepted transaction and advance the state
  task automatic predict_rates(input veh_item_t it, output rate_set_t r);
    bit     flag;
    longint v, sh, ch, ss, cs, t1, t2, c, sy, sd, cd;
    longint dx, dy, dh, dv, ds, dl;
    int     eff;
    flag = 1'b0;
    dx = 0; dy = 0; dh = 0; dv = 0; ds = 0; dl = 0;
    eff = (links_cfg > LINK_CAP) ? LINK_CAP : links_cfg;
    r.num = '0;
    if (!it.kind) begin
      v = it.speed;
      angle_sincos(it.heading, sh, ch);
      angle_sincos(it.steer, ss, cs);
      t1 = round_shift(v * ss, 30);
      if (fwd_mode) begin
        c  = round_shift(ch * cs, 30);
        sy = round_shift(sh * cs, 30);
        dx = clip(round_shift(v * c, 30), 24, flag);
        dy = clip(round_shift(v * sy, 30), 24, flag);
        dh = clip(round_shift(t1 * inv_body, 20), 24, flag);
      end else begin
        t2 = t1 * inv_body * 1024;
        dx = clip(round_shift(v * ch, 30), 24, flag);
        dy = clip(round_shift(v * sh, 30), 24, flag);
        // tangent with a zero cosine: pin to the numerator's sign
        if (cs == 0) begin
          if (t2 > 0) begin
            dh = 8388607; flag = 1'b1;
          end else if (t2 < 0) begin
            dh = -8388608; flag = 1'b1;
          end
        end else begin
          dh = clip(t2 / cs, 24, flag);
        end
      end
      dv = it.accel;
      ds = it.steer_rate;
      coeff_q16 = clip(round_shift(v * inv_hitch, 16), 32, flag);
      prev_ang = it.heading;
      link_pos = 0;
      r.last = (eff == 0);
    end else begin
      angle_sincos(prev_ang - longint'(it.link_angle), sd, cd);
      dl = clip(round_shift(coeff_q16 * sd, 34), 24, flag);
      coeff_q16 = clip(round_shift(coeff_q16 * cd, 30), 32, flag);
      prev_ang = it.link_angle;
      if (link_pos < 15) link_pos++;
      r.num = link_pos[3:0];
      r.last = (link_pos == eff);
    end
    r.dx = dx[23:0]; r.dy = dy[23:0]; r.dh = dh[23:0];
    r.dv = dv[23:0]; r.ds = ds[23:0]; r.dl = dl[23:0];
    r.sat = flag;
  endtask

  // Driver: bursts of transactions separated by random gaps
  veh_item_t cur_item;
  rate_set_t new_rates;
  int        burst_left, gap_left;
  bit        offering;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      offering = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_rates(cur_item, new_rates);
        expected_rates.push_back(new_rates);
        n_accepted <= n_accepted + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_item.kind;
          in_tdata <= {cur_item.link_angle, cur_item.steer_rate, cur_item.accel,
                       cur_item.steer, cur_item.speed, cur_item.heading};
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          // hold a gap after each burst, sometimes none at all
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: own stall pattern, switching mode whenever a random countdown runs out,
  // plus one long hold-off while the sender keeps offering
  int        hold_left, mode_cnt, rdy_mode;
  bit        hold_done;
  logic [15:0] stall_pat;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      mode_cnt <= 0;
      rdy_mode <= 0;
      stall_pat <= 16'hB5C3;
    end else if (!hold_done && n_accepted >= 400) begin
      hold_done <= 1'b1;
      hold_left <= 900;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15] ^ stall_pat[13]};
      if (mode_cnt == 0) begin
        mode_cnt <= $urandom_range(100, 400);
        rdy_mode <= $urandom_range(0, 2);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (rdy_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= stall_pat[0];
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  rate_set_t want, got;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.dx = out_tdata[23:0];    got.dy = out_tdata[47:24];
      got.dh = out_tdata[71:48];   got.dv = out_tdata[95:72];
      got.ds = out_tdata[119:96];  got.dl = out_tdata[143:120];
      got.num = out_tdata[147:144];
      got.last = out_tlast;
      got.sat = out_tuser;
      if (expected_rates.size() == 0) begin
        failed = 1'b1;
        n_mismatch++;
        if (n_mismatch <= 10) $display("result with nothing expected: %p", got);
      end else begin
        want = expected_rates.pop_front();
        if (got != want) begin
          failed = 1'b1;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("rate mismatch at %0t\n  exp %p\n  got %p", $realtime, want, got);
        end
      end
    end
  end

  function automatic veh_item_t make_head();
    veh_item_t it;
    it.kind = 1'b0;
    it.heading = 16'($urandom);
    it.steer = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, 12000) - 6000);
    it.speed = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                            : 24'($urandom_range(0, 131072) - 65536);
    it.accel = 24'($urandom);
    it.steer_rate = 24'($urandom);
    it.link_angle = 16'($urandom);
    return it;
  endfunction

  function automatic veh_item_t make_link();
    veh_item_t it;
    it = make_head();
    it.kind = 1'b1;
    return it;
  endfunction

  function automatic veh_item_t head_of(int h, int v, int s, int a, int r);
    veh_item_t it;
    it = make_head();
    it.heading = 16'(h); it.speed = 24'(v); it.steer = 16'(s);
    it.accel = 24'(a); it.steer_rate = 24'(r);
    return it;
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_rates.size() != 0);
    // let the block settle before the next step
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[23:0];
    case (idx)
      CFG_FWD:   fwd_mode = val[0];
      CFG_INV_L: inv_body = val & 24'hFFFFFF;
      CFG_INV_H: inv_hitch = val & 24'hFFFFFF;
      CFG_LINKS: links_cfg = val & 4'hF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Well-formed vehicle runs with random content, plus broken and stray ones
  task automatic fill_runs(int count);
    int made, eff, nl;
    made = 0;
    eff = (links_cfg > LINK_CAP) ? LINK_CAP : links_cfg;
    while (made < count) begin
      pending_items.push_back(make_head());
      made++;
      nl = eff;
      case ($urandom_range(0, 9))
        0: nl = $urandom_range(0, eff);
        1: nl = eff + $urandom_range(1, 9);
        default: ;
      endcase
      repeat (nl) pending_items.push_back(make_link());
      made += nl;
    end
  endtask

  initial begin
    fwd_mode = 1'b0; inv_body = 1048576; inv_hitch = 1048576; links_cfg = 0;
    coeff_q16 = 0; prev_ang = 0; link_pos = 0;
    n_accepted = 0; n_mismatch = 0; failed = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: link before any head, then field extremes near zero cosine and pi
    pending_items.push_back(make_link());
    pending_items.push_back(head_of(32767, 8388607, 6434, 8388607, -8388608));
    pending_items.push_back(head_of(-32768, -8388608, -6434, -8388608, 8388607));
    pending_items.push_back(head_of(0, 8388607, 6433, 0, 0));
    pending_items.push_back(head_of(12868, 4096, 12868, 1, -1));
    pending_items.push_back(head_of(0, 0, 0, 0, 0));
    pending_items.push_back(make_link());
    pending_items.push_back(head_of(-6434, 8388607, 32767, 0, 0));
    pending_items.push_back(head_of(6434, -8388608, -32768, 0, 0));
    wait_drained();

    write_reg(CFG_FWD, 1);
    write_reg(CFG_INV_L, 16777215);
    write_reg(CFG_INV_H, 16777215);
    write_reg(CFG_LINKS, 2);
    pending_items.push_back(head_of(32767, 8388607, 6434, 0, 0));
    pending_items.push_back(make_link());
    pending_items.push_back(make_link());
    pending_items.push_back(head_of(-32768, -8388608, -32768, 0, 0));
    pending_items.push_back(make_link());
    pending_items.push_back(make_link());
    pending_items.push_back(make_link());
    pending_items.push_back(head_of(0, 8388607, 6434, 0, 0));
    fill_runs(250);
    wait_drained();

    // Walk through extreme and random settings, link counts above the cap too
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_FWD, 0); write_reg(CFG_INV_L, 1);
          write_reg(CFG_INV_H, 1); write_reg(CFG_LINKS, 8);
        end
        1: begin
          write_reg(CFG_INV_L, 16777215); write_reg(CFG_INV_H, 16777215);
          write_reg(CFG_LINKS, 15);
        end
        2: begin
          write_reg(CFG_FWD, 1); write_reg(CFG_LINKS, 0);
          write_reg(CFG_INV_L, 1); write_reg(CFG_INV_H, 16777215);
        end
        default: begin
          write_reg(CFG_FWD, $urandom_range(0, 1));
          write_reg(CFG_INV_L, $urandom_range(1, 16777215));
          write_reg(CFG_INV_H, $urandom_range(1, 16777215));
          write_reg(CFG_LINKS, $urandom_range(0, 9));
        end
      endcase
      fill_runs(170);
      wait_drained();
    end

    if (!failed && expected_rates.size() == 0) begin
      $display("car_trailer_kinematics_derivative_unit: match");
    end else begin
      $display("car_trailer_kinematics_derivative_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("car_trailer_kinematics_derivative_unit: mismatch");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ctkd_pkg.sv
rtl/ctkd_cordic.sv
rtl/car_trailer_kinematics_derivative_unit.sv
tb/tb.sv
